FILE: design/lxd_pkg.sv
// ----------------------------------------------------------------------------
// lxd_pkg
// Shared constants, register codes and types for the local extremum detector.
// ----------------------------------------------------------------------------
package lxd_pkg;

   // Window and stream geometry
   localparam int WINDOW_SIZE = 3;
   localparam int WIN_TAPS    = WINDOW_SIZE * WINDOW_SIZE;
   localparam int TAP_BITS    = $clog2(WIN_TAPS);
   localparam int MAX_WIDTH   = 1024;
   localparam int PIXEL_BITS  = 16;
   localparam int LINE_BITS   = 2 * PIXEL_BITS;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int CFG_BITS    = 11;
   localparam int DELAY_BITS  = $clog2(2 * MAX_WIDTH + 3);
   localparam int MASK_BITS   = WIN_TAPS;

   // Result queue
   localparam int Q_DEPTH     = 4;
   localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 3);

   // Register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIND_MINIMUM   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FOOTPRINT_MASK = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIGIN_ROW     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIGIN_COL     = 3'd5;

   // Register reset values
   localparam logic [CFG_BITS-1:0]  RST_DIM  = CFG_BITS'(1024);
   localparam logic [MASK_BITS-1:0] RST_MASK = '1;

   // Normalized origin codes (two's complement)
   localparam logic [1:0] ORIGIN_ZERO  = 2'b00;
   localparam logic [1:0] ORIGIN_PLUS  = 2'b01;
   localparam logic [1:0] ORIGIN_MINUS = 2'b11;

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   typedef struct packed {
      logic is_extremum;
      logic frame_end;
   } result_type;

endpackage

FILE: design/local_extremum_detector.sv
// ----------------------------------------------------------------------------
// local_extremum_detector
// Flags local maxima or minima of a raster pixel stream over a masked 3x3
// footprint, using a column-addressed line memory and a sliding window.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle, pixel or flush word, while the
// result queue has room; the rate is set by the line memory, a 1024 x 32 RAM
// read and written once per word (read at accept, written back in the next
// cycle, with a bypass when the same column repeats). The result for pixel p
// is produced by frame word p + D, D = (1-origin_row)*width + (1-origin_col),
// and reaches the rsp side through stage B, stage C and the result queue.
// After the last pixel the source sends D flush words (pad set). Configuration
// is sampled at the first word of each frame. A four-word result queue lets
// input continue while results wait. No clearing pass is needed after reset.
module local_extremum_detector (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lxd_pkg::PIXEL_BITS-1:0]       req_pixel_value,
   input  logic                                 req_pad,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_is_extremum,
   output logic                                 rsp_frame_end,
   input  logic                                 csr_wr_en,
   input  logic [lxd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lxd_pkg::CFG_BITS-1:0]         csr_wr_data
);
   import lxd_pkg::*;

   // Configuration registers
   logic [CFG_BITS-1:0]  width_ff, height_ff;
   logic                 find_min_ff;
   logic [MASK_BITS-1:0] mask_ff;
   logic [1:0]           orow_raw_ff, ocol_raw_ff;

   // Normalized configuration
   logic [CFG_BITS-1:0]   norm_width, norm_height;
   logic [1:0]            norm_orow, norm_ocol;
   logic [DELAY_BITS-1:0] norm_delay, row_term, col_term;

   // Frame copy of configuration
   logic [CFG_BITS-1:0]   fw_ff, fh_ff;
   logic                  fmin_ff;
   logic [MASK_BITS-1:0]  fmask_ff;
   logic [1:0]            forow_ff, focol_ff;
   logic [DELAY_BITS-1:0] fdelay_ff;

   // Values in force for the word at the input
   logic [CFG_BITS-1:0]   cur_w, cur_h;
   logic [DELAY_BITS-1:0] cur_delay;

   // Frame control
   logic                  busy_ff, busy_in;
   logic [DELAY_BITS-1:0] lead_ff, lead_in;
   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [CFG_BITS-1:0]   out_row_ff, out_row_in;
   logic [COL_BITS-1:0]   out_col_ff, out_col_in;
   logic                  take, frame_take, has_res, frame_last;
   logic                  col_wrap, out_col_wrap;

   // Line memory and bypass
   logic [LINE_BITS-1:0]  line_mem [MAX_WIDTH];
   logic [LINE_BITS-1:0]  line_rd_ff, line_rd;
   logic                  byp_ff;
   logic [LINE_BITS-1:0]  byp_data_ff;

   // Stage B: line read returned, window shift
   logic                  v_b_ff, res_b_ff, last_b_ff;
   pixel_type             pix_b_ff;
   logic [COL_BITS-1:0]   col_b_ff;
   logic [CFG_BITS-1:0]   out_row_b_ff;
   logic [COL_BITS-1:0]   out_col_b_ff;
   logic [WINDOW_SIZE-1:0] row_ok, col_ok;
   logic [WIN_TAPS-1:0]   en_b;
   logic [TAP_BITS-1:0]   piv_b;
   logic [1:0]            piv_r, piv_c;
   pixel_type             win_ff [WIN_TAPS];
   pixel_type             col_new [WINDOW_SIZE];

   // Stage C: compare
   logic                  v_c_ff, res_c_ff, last_c_ff, fmin_c_ff;
   logic [TAP_BITS-1:0]   piv_c_ff;
   logic [WIN_TAPS-1:0]   en_c_ff;
   pixel_type             pivot;
   logic                  fail;

   // Result queue
   result_type            q_mem [Q_DEPTH];
   logic [Q_PTR_BITS-1:0] q_wr_ff, q_rd_ff;
   logic [Q_CNT_BITS-1:0] q_count_ff, q_pending;
   logic                  q_push, q_pop;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= RST_DIM;
         height_ff   <= RST_DIM;
         find_min_ff <= 1'b0;
         mask_ff     <= RST_MASK;
         orow_raw_ff <= ORIGIN_ZERO;
         ocol_raw_ff <= ORIGIN_ZERO;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:    width_ff    <= csr_wr_data;
            CSR_IMAGE_HEIGHT:   height_ff   <= csr_wr_data;
            CSR_FIND_MINIMUM:   find_min_ff <= csr_wr_data[0];
            CSR_FOOTPRINT_MASK: mask_ff     <= csr_wr_data[MASK_BITS-1:0];
            CSR_ORIGIN_ROW:     orow_raw_ff <= csr_wr_data[1:0];
            CSR_ORIGIN_COL:     ocol_raw_ff <= csr_wr_data[1:0];
            default: ;
         endcase
      end
   end

   // Clamp sizes, saturate origins, derive the result delay
   always_comb begin
      if (width_ff == '0) begin
         norm_width = CFG_BITS'(1);
      end else if (width_ff > CFG_BITS'(MAX_WIDTH)) begin
         norm_width = CFG_BITS'(MAX_WIDTH);
      end else begin
         norm_width = width_ff;
      end
      norm_height = (height_ff == '0) ? CFG_BITS'(1) : height_ff;
      norm_orow   = orow_raw_ff[1] ? ORIGIN_MINUS : orow_raw_ff;
      norm_ocol   = ocol_raw_ff[1] ? ORIGIN_MINUS : ocol_raw_ff;
      case (norm_orow)
         ORIGIN_PLUS: row_term = '0;
         ORIGIN_ZERO: row_term = {1'b0, norm_width};
         default:     row_term = {norm_width, 1'b0};
      endcase
      case (norm_ocol)
         ORIGIN_PLUS: col_term = DELAY_BITS'(0);
         ORIGIN_ZERO: col_term = DELAY_BITS'(1);
         default:     col_term = DELAY_BITS'(2);
      endcase
      norm_delay = row_term + col_term;
   end

   // Input side bookkeeping
   assign cur_w     = busy_ff ? fw_ff     : norm_width;
   assign cur_h     = busy_ff ? fh_ff     : norm_height;
   assign cur_delay = busy_ff ? fdelay_ff : norm_delay;

   assign take         = req_valid && req_ready;
   assign frame_take   = take && (busy_ff || !req_pad);
   assign has_res      = (lead_ff >= cur_delay);
   assign col_wrap     = ({1'b0, col_ff} == (cur_w - CFG_BITS'(1)));
   assign out_col_wrap = ({1'b0, out_col_ff} == (cur_w - CFG_BITS'(1)));
   assign frame_last   = has_res && out_col_wrap && (out_row_ff == (cur_h - CFG_BITS'(1)));

   always_comb begin
      busy_in    = busy_ff;
      lead_in    = lead_ff;
      col_in     = col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (frame_take) begin
         busy_in = !frame_last;
         if (frame_last) begin
            lead_in    = '0;
            col_in     = '0;
            out_row_in = '0;
            out_col_in = '0;
         end else begin
            col_in = col_wrap ? '0 : col_ff + COL_BITS'(1);
            if (!has_res) begin
               lead_in = lead_ff + DELAY_BITS'(1);
            end else if (out_col_wrap) begin
               out_col_in = '0;
               out_row_in = out_row_ff + CFG_BITS'(1);
            end else begin
               out_col_in = out_col_ff + COL_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         lead_ff    <= '0;
         col_ff     <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         lead_ff    <= lead_in;
         col_ff     <= col_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
      end
   end

   // Frame copy of configuration, taken at the first word
   always_ff @(posedge clock) begin
      if (frame_take && !busy_ff) begin
         fw_ff     <= norm_width;
         fh_ff     <= norm_height;
         fmin_ff   <= find_min_ff;
         fmask_ff  <= mask_ff;
         forow_ff  <= norm_orow;
         focol_ff  <= norm_ocol;
         fdelay_ff <= norm_delay;
      end
   end

   // Line memory: word at column a holds {x[m], x[m-width]} of the last word m
   // at that column; read at accept, written back in the next cycle
   assign line_rd = byp_ff ? byp_data_ff : line_rd_ff;

   always_ff @(posedge clock) begin
      if (v_b_ff) begin
         line_mem[col_b_ff] <= {pix_b_ff, line_rd[PIXEL_BITS +: PIXEL_BITS]};
      end
      if (frame_take) begin
         line_rd_ff <= line_mem[col_ff];
      end
   end

   // Bypass for a read of the column being written back in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= frame_take && v_b_ff && (col_ff == col_b_ff);
      end
      byp_data_ff <= {pix_b_ff, line_rd[PIXEL_BITS +: PIXEL_BITS]};
   end

   // Stage B registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v_b_ff <= 1'b0;
      end else begin
         v_b_ff <= frame_take;
      end
      if (frame_take) begin
         res_b_ff     <= has_res;
         last_b_ff    <= frame_last;
         pix_b_ff     <= req_pixel_value;
         col_b_ff     <= col_ff;
         out_row_b_ff <= out_row_ff;
         out_col_b_ff <= out_col_ff;
      end
   end

   // Stage B: which window taps lie inside the image, and the pivot tap
   always_comb begin
      logic signed [2:0]          roff, coff;
      logic signed [CFG_BITS+1:0] rpos, cpos;
      for (int k = 0; k < WINDOW_SIZE; k++) begin
         roff = $signed(3'(k)) - 3'sd1 - $signed({forow_ff[1], forow_ff});
         coff = $signed(3'(k)) - 3'sd1 - $signed({focol_ff[1], focol_ff});
         rpos = $signed({2'b00, out_row_b_ff}) +
                $signed({{(CFG_BITS-1){roff[2]}}, roff});
         cpos = $signed({3'b000, out_col_b_ff}) +
                $signed({{(CFG_BITS-1){coff[2]}}, coff});
         row_ok[k] = !rpos[CFG_BITS+1] && (rpos < $signed({2'b00, fh_ff}));
         col_ok[k] = !cpos[CFG_BITS+1] && (cpos < $signed({2'b00, fw_ff}));
      end
      for (int kr = 0; kr < WINDOW_SIZE; kr++) begin
         for (int kc = 0; kc < WINDOW_SIZE; kc++) begin
            en_b[kr*WINDOW_SIZE+kc] = fmask_ff[kr*WINDOW_SIZE+kc] && row_ok[kr] && col_ok[kc];
         end
      end
      piv_r = forow_ff + 2'd1;
      piv_c = focol_ff + 2'd1;
      piv_b = TAP_BITS'({piv_r, 1'b0}) + TAP_BITS'(piv_r) + TAP_BITS'(piv_c);
   end

   // New window column: two rows up, one row up, current word
   assign col_new[0] = line_rd[0 +: PIXEL_BITS];
   assign col_new[1] = line_rd[PIXEL_BITS +: PIXEL_BITS];
   assign col_new[2] = pix_b_ff;

   // Window shift, one column per word
   always_ff @(posedge clock) begin
      if (v_b_ff) begin
         for (int kr = 0; kr < WINDOW_SIZE; kr++) begin
            for (int kc = 0; kc < WINDOW_SIZE - 1; kc++) begin
               win_ff[kr*WINDOW_SIZE+kc] <= win_ff[kr*WINDOW_SIZE+kc+1];
            end
            win_ff[kr*WINDOW_SIZE+WINDOW_SIZE-1] <= col_new[kr];
         end
      end
   end

   // Stage C registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v_c_ff <= 1'b0;
      end else begin
         v_c_ff <= v_b_ff;
      end
      if (v_b_ff) begin
         res_c_ff  <= res_b_ff;
         last_c_ff <= last_b_ff;
         fmin_c_ff <= fmin_ff;
         piv_c_ff  <= piv_b;
         en_c_ff   <= en_b;
      end
   end

   // Stage C: compare enabled taps against the pivot; ties pass
   always_comb begin
      pivot = win_ff[piv_c_ff];
      fail  = 1'b0;
      for (int k = 0; k < WIN_TAPS; k++) begin
         if (en_c_ff[k] && (fmin_c_ff ? (win_ff[k] < pivot) : (win_ff[k] > pivot))) begin
            fail = 1'b1;
         end
      end
   end

   // Result queue; input is held off when queued plus in-flight results fill it
   assign q_push    = v_c_ff && res_c_ff;
   assign q_pop     = rsp_valid && rsp_ready;
   assign q_pending = q_count_ff + Q_CNT_BITS'(v_b_ff && res_b_ff)
                                 + Q_CNT_BITS'(v_c_ff && res_c_ff);
   assign req_ready = (q_pending < Q_CNT_BITS'(Q_DEPTH));

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_mem[q_wr_ff] <= '{is_extremum: !fail, frame_end: last_c_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff    <= '0;
         q_rd_ff    <= '0;
         q_count_ff <= '0;
      end else begin
         if (q_push) begin
            q_wr_ff <= q_wr_ff + Q_PTR_BITS'(1);
         end
         if (q_pop) begin
            q_rd_ff <= q_rd_ff + Q_PTR_BITS'(1);
         end
         q_count_ff <= q_count_ff + Q_CNT_BITS'(q_push) - Q_CNT_BITS'(q_pop);
      end
   end

   assign rsp_valid       = (q_count_ff != '0);
   assign rsp_is_extremum = q_mem[q_rd_ff].is_extremum;
   assign rsp_frame_end   = q_mem[q_rd_ff].frame_end;

   // Checks
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> ((q_count_ff < Q_CNT_BITS'(Q_DEPTH)) || rsp_ready))
      else $error("result queue overflow");

   a_lead_bounded: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (lead_ff <= fdelay_ff))
      else $error("lead counter passed the frame delay");

   a_out_col_in_row: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ({1'b0, out_col_ff} < fw_ff))
      else $error("pending pixel column outside the row");

endmodule
